// ----- src/brb_pkg.sv -----
package brb_pkg;

  localparam int DEPTH_DEF   = 1024;
  localparam int MAX_RUN_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int LEN_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 10;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [FILL_W-1:0]   fill_t;

  localparam action_t ACT_APPEND = 2'd0;
  localparam action_t ACT_PEEK   = 2'd1;
  localparam action_t ACT_POP    = 2'd2;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_REJ = 1'b1;

endpackage

// ----- src/brb_if.sv -----
interface brb_in_if import brb_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  len_t    length;
  byte_t   data_byte;
  logic    first_of_run;

  modport source (output valid, action, length, data_byte, first_of_run, input ready);
  modport sink   (input valid, action, length, data_byte, first_of_run, output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t read_byte;
  logic  status;
  logic  last;
  fill_t fill_level;

  modport source (output valid, read_byte, status, last, fill_level, input ready);
  modport sink   (input valid, read_byte, status, last, fill_level, output ready);
endinterface

// ----- src/brb_ram.sv -----
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/byte_ring_buffer.sv -----
// Byte ring buffer. Append, pop and every rejected or zero-length request take one word
// and answer it with one result word, which is registered and appears the cycle after acceptance.
// An accepted peek of n bytes does one RAM read and one result load per byte, all through
// the single registered read port of the byte store; each byte waits until the result word
// has room, and no new word is taken meanwhile. Synchronous active-low reset empties the
// buffer and cancels any open run; the byte store itself is not cleared and needs no clearing pass.
module byte_ring_buffer import brb_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  brb_in_if.sink        in_ch,
  brb_out_if.source     out_ch
);

  // Pointer width, and the width of sums of a pointer or count with a request length.
  localparam int PW = $clog2(DEPTH);
  localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [SW-1:0] CAP_S    = SW'(DEPTH - 1);
  localparam len_t          MAX_LEN  = LEN_W'(MAX_RUN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEK_REQ,
    ST_PEEK_DATA
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic          run_acc_r, run_acc_nxt;
  len_t          run_rem_r, run_rem_nxt;
  len_t          pk_len_r, pk_len_nxt;
  len_t          pk_off_r, pk_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  logic          out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;
  fill_t         out_fill_r, out_fill_nxt;

  logic          in_accept;
  logic          out_free;
  logic          out_load;

  logic [PW:0]   diff;
  logic [PW-1:0] cnt;
  logic [SW-1:0] cnt_s;
  logic [SW-1:0] len_s;
  logic          len_big;
  logic          short_data;
  logic [SW-1:0] cnt_after_pop;

  // The shared add-and-wrap unit: read pointer plus an offset, modulo DEPTH. It computes
  // the new read pointer of a pop and the byte address of every peek read.
  len_t          add_op;
  logic [SW-1:0] add_sum;
  logic [SW-1:0] add_wrap;
  logic [PW-1:0] rp_plus;

  logic [PW-1:0] wp_inc;

  logic          ram_we;
  byte_t         ram_rdata;

  function automatic fill_t fill_of(input logic [PW-1:0] c);
    logic [PW+FILL_W-1:0] e;
    e = {{FILL_W{1'b0}}, c};
    return e[FILL_W-1:0];
  endfunction

  // Stored count is the pointer distance modulo DEPTH.
  assign diff  = {1'b0, wp_r} - {1'b0, rp_r};
  assign cnt   = diff[PW] ? diff[PW-1:0] + PW'(DEPTH) : diff[PW-1:0];
  assign cnt_s = SW'(cnt);
  assign len_s = SW'(in_ch.length);

  assign len_big       = in_ch.length > MAX_LEN;
  assign short_data    = len_s > cnt_s;
  assign cnt_after_pop = cnt_s - len_s;

  assign add_op   = (state_r == ST_IDLE) ? in_ch.length : pk_off_r;
  assign add_sum  = SW'(rp_r) + SW'(add_op);
  assign add_wrap = (add_sum >= DEPTH_S) ? add_sum - DEPTH_S : add_sum;
  assign rp_plus  = add_wrap[PW-1:0];

  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_accept    = in_ch.valid && in_ch.ready;

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.data_byte),
    .raddr (rp_plus),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    run_acc_nxt    = run_acc_r;
    run_rem_nxt    = run_rem_r;
    pk_len_nxt     = pk_len_r;
    pk_off_nxt     = pk_off_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_fill_nxt   = out_fill_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // Every request except an accepted nonzero peek answers with one word now.
          out_load       = 1'b1;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_REJ;
          out_fill_nxt   = fill_of(cnt);
          case (in_ch.action)
            ACT_APPEND: begin
              // The first word of a run reserves space for the whole run or rejects it.
              if (in_ch.first_of_run) begin
                if (len_big || (cnt_s + len_s > CAP_S)) begin
                  run_acc_nxt = 1'b0;
                  run_rem_nxt = '0;
                end else begin
                  run_acc_nxt    = 1'b1;
                  run_rem_nxt    = in_ch.length;
                  out_status_nxt = STAT_OK;
                end
              end
              if (run_acc_nxt && (run_rem_nxt != '0)) begin
                ram_we         = 1'b1;
                wp_nxt         = wp_inc;
                run_rem_nxt    = run_rem_nxt - LEN_W'(1);
                out_status_nxt = STAT_OK;
                out_fill_nxt   = fill_of(cnt + PW'(1));
              end
            end
            ACT_PEEK: begin
              if (!len_big && !short_data) begin
                if (in_ch.length == '0) begin
                  out_status_nxt = STAT_OK;
                end else begin
                  out_load   = 1'b0;
                  pk_len_nxt = in_ch.length;
                  pk_off_nxt = '0;
                  state_nxt  = ST_PEEK_REQ;
                end
              end
            end
            ACT_POP: begin
              if (!len_big && !short_data) begin
                rp_nxt         = rp_plus;
                out_status_nxt = STAT_OK;
                out_fill_nxt   = fill_of(cnt_after_pop[PW-1:0]);
              end
            end
            default: begin
              out_status_nxt = STAT_REJ;
            end
          endcase
          if (out_load) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_PEEK_REQ: begin
        // The read address is presented now; wait until the result word has room.
        if (out_free) begin
          state_nxt = ST_PEEK_DATA;
        end
      end
      ST_PEEK_DATA: begin
        out_load       = 1'b1;
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = ram_rdata;
        out_status_nxt = STAT_OK;
        out_fill_nxt   = fill_of(cnt);
        out_last_nxt   = (pk_off_r + LEN_W'(1)) == pk_len_r;
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end else begin
          pk_off_nxt = pk_off_r + LEN_W'(1);
          state_nxt  = ST_PEEK_REQ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      run_acc_r   <= 1'b0;
      run_rem_r   <= '0;
      pk_len_r    <= '0;
      pk_off_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      run_acc_r   <= run_acc_nxt;
      run_rem_r   <= run_rem_nxt;
      pk_len_r    <= pk_len_nxt;
      pk_off_r    <= pk_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_byte  = out_byte_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.fill_level = out_fill_r;

`ifndef SYNTHESIS
  // A result word is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten");

  // Bytes still owed to an open run always fit in the space it reserved.
  a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
    run_acc_r |-> ((cnt_s + SW'(run_rem_r)) <= CAP_S))
    else $error("open run exceeds reserved space");

  // During a peek the byte offset stays inside the requested length.
  a_peek_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (pk_off_r < pk_len_r))
    else $error("peek offset out of range");

  // When peek data returns from the store, the result register is free.
  a_data_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PEEK_DATA) |-> !out_valid_r)
    else $error("peek data with result register busy");
`endif

endmodule

// ----- tb/sv/brb_check.sv -----
module brb_check import brb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  brb_in_if    in_mon,
  brb_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    byte_t read_byte;
    logic  status;
    logic  last;
    fill_t fill_level;
  } ring_result_t;

  // Shadow copy of the buffer contents and pointers.
  byte_t ring_store [DEPTH_DEF];
  int    head_ptr = 0;
  int    tail_ptr = 0;
  bit    run_live = 1'b0;
  int    run_left = 0;

  ring_result_t pending_results[$];
  ring_result_t seen;
  ring_result_t want;
  int           mismatches = 0;

  function automatic int bytes_held();
    return (tail_ptr + DEPTH_DEF - head_ptr) % DEPTH_DEF;
  endfunction

  function automatic void push_result(byte_t rd, logic st, logic lst);
    ring_result_t res;
    res.read_byte  = rd;
    res.status     = st;
    res.last       = lst;
    res.fill_level = fill_t'(bytes_held());
    pending_results.push_back(res);
  endfunction

  // Works out every result word that one accepted request word causes.
  function automatic void apply_request(action_t act, len_t len, byte_t data, logic first);
    int   held;
    int   i;
    logic st;
    held = bytes_held();
    st   = STAT_REJ;
    case (act)
      ACT_APPEND: begin
        if (first) begin
          if (len > MAX_RUN_DEF || held + int'(len) > DEPTH_DEF - 1) begin
            run_live = 1'b0;
            run_left = 0;
          end else begin
            run_live = 1'b1;
            run_left = int'(len);
            st       = STAT_OK;
          end
        end
        if (run_live && run_left > 0) begin
          ring_store[tail_ptr] = data;
          tail_ptr = (tail_ptr + 1) % DEPTH_DEF;
          run_left--;
          st = STAT_OK;
        end
        push_result('0, st, 1'b1);
      end
      ACT_PEEK: begin
        if (len > MAX_RUN_DEF || int'(len) > held) begin
          push_result('0, STAT_REJ, 1'b1);
        end else if (len == 0) begin
          push_result('0, STAT_OK, 1'b1);
        end else begin
          for (i = 0; i < int'(len); i++) begin
            push_result(ring_store[(head_ptr + i) % DEPTH_DEF], STAT_OK, i == int'(len) - 1);
          end
        end
      end
      ACT_POP: begin
        if (len > MAX_RUN_DEF || int'(len) > held) begin
          push_result('0, STAT_REJ, 1'b1);
        end else begin
          head_ptr = (head_ptr + int'(len)) % DEPTH_DEF;
          push_result('0, STAT_OK, 1'b1);
        end
      end
      default: begin
        push_result('0, STAT_REJ, 1'b1);
      end
    endcase
  endfunction

  function automatic void field_check(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        seen.read_byte  = out_mon.read_byte;
        seen.status     = out_mon.status;
        seen.last       = out_mon.last;
        seen.fill_level = out_mon.fill_level;
        if (pending_results.size() == 0) begin
          mismatches++;
          $error("result word with nothing outstanding: read_byte %0d status %0d",
                 seen.read_byte, seen.status);
        end else begin
          want = pending_results.pop_front();
          field_check("read_byte", int'(want.read_byte), int'(seen.read_byte));
          field_check("status", int'(want.status), int'(seen.status));
          field_check("last", int'(want.last), int'(seen.last));
          field_check("fill_level", int'(want.fill_level), int'(seen.fill_level));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_request(in_mon.action, in_mon.length, in_mon.data_byte, in_mon.first_of_run);
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import brb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names no code for the fourth action value, which the block
  // must answer with a single rejection.
  localparam action_t ACT_UNKNOWN = 2'd3;

  // Longest deliberate receiver hold-off, and the watchdog limit on cycles
  // without any accepted word. The limit covers the hold-off several times.
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  brb_in_if  in_bus ();
  brb_out_if out_bus ();

  int fail_count;
  int outstanding;

  // Knobs and counters of the sender, the receiver process and the watchdog.
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int holds_asked  = 0;
  int holds_done   = 0;
  bit tail_calm    = 1'b0;
  int words_sent   = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  byte_ring_buffer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  brb_check CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Offers one request word and returns at the edge where it is taken.
  // A random idle burst may come first, unless the run is in its calm tail.
  task automatic send_word(action_t act, int len, byte_t data, logic first);
    if (!tail_calm && $urandom_range(0, 99) < tx_gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= act;
    in_bus.length       <= len_t'(len);
    in_bus.data_byte    <= data;
    in_bus.first_of_run <= first;
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
  endtask

  // Stops offering and waits until every predicted result word has been
  // taken. The first edge is always waited so that the outstanding count
  // already includes the word accepted last.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A peek, pop or unknown request. In a draining phase the lengths lean
  // long so the buffer empties and the too-little-data case shows up.
  task automatic random_request(bit draining);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) begin
      len = $urandom_range(MAX_RUN_DEF + 1, 127);
    end else if (draining) begin
      len = $urandom_range(16, MAX_RUN_DEF);
    end else begin
      len = $urandom_range(0, MAX_RUN_DEF);
    end
    if (r < 4) begin
      send_word(ACT_UNKNOWN, $urandom_range(0, 127), byte_t'($urandom), 1'($urandom));
    end else if (r < 45) begin
      send_word(ACT_PEEK, len, byte_t'($urandom), 1'($urandom));
    end else begin
      send_word(ACT_POP, len, byte_t'($urandom), 1'($urandom));
    end
  endtask

  // One append run of the given length. Most runs send exactly their bytes;
  // some are cut short by the next run, some overrun with extra bytes that
  // must be dropped, and now and then a peek, pop or unknown request is slipped in between.
  task automatic append_run(int len);
    int r;
    int words;
    int i;
    r     = $urandom_range(0, 9);
    words = len;
    if (r == 0) begin
      words = $urandom_range(0, len);
    end else if (r == 1) begin
      words = len + $urandom_range(1, 3);
    end
    if (words < 1) begin
      words = 1;
    end
    send_word(ACT_APPEND, len, byte_t'($urandom), 1'b1);
    for (i = 1; i < words; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        random_request(1'b0);
      end
      // The length field is ignored after the first byte; random values
      // keep its upper bits moving.
      send_word(ACT_APPEND, $urandom_range(0, 127), byte_t'($urandom), 1'b0);
    end
  endtask

  // A phase of random sequences. The append share steers the fill level:
  // a high share raises it, a low one drains the buffer past empty.
  task automatic run_phase(int sequences, int append_pct, bit long_runs);
    int s;
    int r;
    int len;
    for (s = 0; s < sequences; s++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    tx_gap_pct = 0;
          2:       tx_gap_pct = 8;
          default: tx_gap_pct = 30;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // Stray byte with no run open, or past the end of one.
        send_word(ACT_APPEND, $urandom_range(0, 127), byte_t'($urandom), 1'b0);
      end else if (r < append_pct) begin
        if ($urandom_range(0, 24) == 0) begin
          len = $urandom_range(MAX_RUN_DEF + 1, 127);
        end else if (long_runs) begin
          len = $urandom_range(32, MAX_RUN_DEF);
        end else begin
          len = $urandom_range(0, MAX_RUN_DEF);
        end
        append_run(len);
      end else begin
        random_request(append_pct < 50);
      end
    end
  endtask

  // Receiver: ready in random stall bursts, with the stall rate itself
  // changing now and then so there are calm stretches too. A hold-off
  // request from the sender side keeps ready low long enough for the
  // block to back up and stall its input.
  initial begin
    out_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (!tail_calm && $urandom_range(0, 99) < rx_stall_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 3))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 5;
          2:       rx_stall_pct = 25;
          default: rx_stall_pct = 50;
        endcase
      end
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int mixed_end;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_APPEND;
    in_bus.length       = '0;
    in_bus.data_byte    = '0;
    in_bus.first_of_run = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening on an empty buffer: zero-length pop, peek and pop
    // with too little data, the unknown action, and a stray byte with no
    // run open.
    send_word(ACT_POP, 0, 8'h00, 1'b0);
    send_word(ACT_PEEK, 1, 8'h00, 1'b0);
    send_word(ACT_POP, 1, 8'h00, 1'b0);
    send_word(ACT_UNKNOWN, 0, 8'h00, 1'b0);
    send_word(ACT_APPEND, 5, 8'h11, 1'b0);
    // A zero-length run is accepted but swallows nothing afterwards.
    send_word(ACT_APPEND, 0, 8'h22, 1'b1);
    send_word(ACT_APPEND, 0, 8'h33, 1'b0);
    // Oversized runs are rejected along with their following bytes.
    send_word(ACT_APPEND, MAX_RUN_DEF + 1, 8'h44, 1'b1);
    send_word(ACT_APPEND, 0, 8'h55, 1'b0);
    send_word(ACT_APPEND, 127, 8'hFF, 1'b1);
    // A three-byte run with a peek and a zero-length peek interleaved.
    send_word(ACT_APPEND, 3, 8'h00, 1'b1);
    send_word(ACT_PEEK, 1, 8'h00, 1'b0);
    send_word(ACT_APPEND, 127, 8'hFF, 1'b0);
    send_word(ACT_PEEK, 0, 8'h00, 1'b0);
    send_word(ACT_APPEND, 0, 8'hA5, 1'b0);
    // A new run opened mid-run abandons the rest of the old one.
    send_word(ACT_APPEND, 4, 8'h5A, 1'b1);
    send_word(ACT_APPEND, 0, 8'h33, 1'b0);
    send_word(ACT_APPEND, 2, 8'hC3, 1'b1);
    send_word(ACT_APPEND, 0, 8'h3C, 1'b0);
    // Oversized and too-long reads, then an accepted six-byte peek and pops.
    send_word(ACT_PEEK, MAX_RUN_DEF + 1, 8'h00, 1'b0);
    send_word(ACT_POP, 127, 8'h00, 1'b0);
    send_word(ACT_PEEK, MAX_RUN_DEF, 8'h00, 1'b0);
    send_word(ACT_PEEK, 6, 8'h00, 1'b0);
    send_word(ACT_POP, 2, 8'h00, 1'b0);
    send_word(ACT_POP, 0, 8'h00, 1'b0);
    wait_drained();

    // The fill phase opens with a long receiver hold-off while requests
    // keep coming, so the block backs up and stops taking words. A drain
    // phase then empties the buffer again.
    tx_gap_pct   = 0;
    rx_stall_pct = 25;
    holds_asked++;
    run_phase(3, 90, 1'b1);
    wait_drained();
    run_phase(12, 15, 1'b0);

    // Mixed traffic for the bulk of the random part.
    mixed_end = words_sent + 150;
    while (words_sent < mixed_end) begin
      run_phase(1, 55, 1'b0);
    end

    // Calm tail: no idling on either side.
    tail_calm = 1'b1;
    run_phase(4, 55, 1'b0);

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
